// ----- hw/rtl/nwu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nwu_pkg: shared types and constants for the NewReno window update block
// Widths, register indexes, op codes, reset values, divider handshake structs.
// ----------------------------------------------------------------------------
package nwu_pkg;

	localparam int WORD_W  = 32;
	localparam int SEG_W   = 16;
	localparam int ACK_W   = 8;
	localparam int CIDX_W  = 2;
	localparam int CNT_W   = 5;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_SEGMENT_SIZE      = 2'd0;
	localparam logic [CIDX_W-1:0] REG_INITIAL_WINDOW    = 2'd1;
	localparam logic [CIDX_W-1:0] REG_INITIAL_THRESHOLD = 2'd2;

	// operation codes
	localparam logic OP_ACK        = 1'b0;
	localparam logic OP_CONGESTION = 1'b1;

	// reset values
	localparam logic [SEG_W-1:0]  RST_SEGMENT_SIZE      = 16'd536;
	localparam logic [WORD_W-1:0] RST_INITIAL_WINDOW    = 32'd5360;
	localparam logic [WORD_W-1:0] RST_INITIAL_THRESHOLD = 32'hFFFF_FFFF;
	localparam logic [WORD_W-1:0] WIN_MAX               = 32'hFFFF_FFFF;

	// divider control and status
	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage : nwu_pkg
`default_nettype wire

// ----- hw/rtl/nwu_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nwu_divider: iterative restoring unsigned divider
// One quotient bit per cycle through a single shared subtractor; when the
// last bit of a 32-bit divide is in, done pulses for one cycle.
// ----------------------------------------------------------------------------
module nwu_divider (
	input  wire                          clk,
	input  wire                          arst_n,
	input  nwu_pkg::div_ctrl_t           ctrl,
	input  wire [nwu_pkg::WORD_W-1:0]    dividend,
	input  wire [nwu_pkg::WORD_W-1:0]    divisor,
	output nwu_pkg::div_stat_t           stat,
	output logic [nwu_pkg::WORD_W-1:0]   quotient
);
	import nwu_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] dsr_q;
	logic [WORD_W:0]   rem_sh;
	logic [WORD_W+1:0] trial;

	// shift in the next dividend bit and try the subtraction
	assign rem_sh = {rem_q, quo_q[WORD_W-1]};
	assign trial  = {1'b0, rem_sh} - {2'b00, dsr_q};

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: keep remainder when the trial goes negative
	always_ff @(posedge clk) begin
		if (ctrl.start && !busy_q) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[WORD_W+1]) begin
				rem_q <= trial[WORD_W-1:0];
			end else begin
				rem_q <= rem_sh[WORD_W-1:0];
			end
			quo_q <= {quo_q[WORD_W-2:0], ~trial[WORD_W+1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule : nwu_divider
`default_nettype wire

// ----- hw/rtl/newreno_window_update.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// newreno_window_update: NewReno congestion window and slow start threshold
// Sequencer around a single iterative divider for the avoidance increment.
// ----------------------------------------------------------------------------
// One item at a time. A congestion event goes from accept straight to the
// finish state; an acknowledgement passes a check state first, and one
// with an avoidance step then goes through the start and divide states:
// the increment seg*seg/window comes from a restoring divider that
// produces one quotient bit per cycle, and is added to the window when the
// divider is done. The finish state loads the result, and the block is
// ready again as soon as it is loaded. The result sits in an output
// register, so the next item is taken while it waits; that item's result
// waits until the previous one is taken. Writing initial_window or
// initial_threshold also loads the live window or threshold at once.
module newreno_window_update (
	input  wire                         clk,
	input  wire                         arst_n,
	// configuration
	input  wire                         cfg_we,
	input  wire [nwu_pkg::CIDX_W-1:0]   cfg_index,
	input  wire [nwu_pkg::WORD_W-1:0]   cfg_data,
	// input items
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire                         operation,
	input  wire [nwu_pkg::ACK_W-1:0]    segments_acked,
	input  wire [nwu_pkg::WORD_W-1:0]   bytes_in_flight,
	// result items
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic [nwu_pkg::WORD_W-1:0]  window_bytes,
	output logic [nwu_pkg::WORD_W-1:0]  threshold_bytes,
	output logic [nwu_pkg::ACK_W-1:0]   unused_segments,
	output logic                        in_slow_start
);
	import nwu_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHECK  = 3'd1;
	localparam logic [2:0] ST_START  = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0]        state_q;
	logic [SEG_W-1:0]  seg_q;
	logic [WORD_W-1:0] window_q;
	logic [WORD_W-1:0] threshold_q;
	logic [ACK_W-1:0]  left_q;
	logic [WORD_W-1:0] sq_q;
	logic [WORD_W-1:0] dsr_q;

	logic              out_valid_q;
	logic [WORD_W-1:0] out_win_q;
	logic [WORD_W-1:0] out_thr_q;
	logic [ACK_W-1:0]  out_left_q;
	logic              out_ss_q;

	logic              accept;
	logic              out_free;
	logic [WORD_W:0]   ss_sum;
	logic [WORD_W-1:0] ss_win;
	logic [WORD_W-1:0] half;
	logic [WORD_W-1:0] floor2;
	logic [WORD_W-1:0] seg_word;
	logic [WORD_W-1:0] inc;
	logic [WORD_W:0]   ca_sum;
	logic [WORD_W-1:0] ca_win;

	div_ctrl_t         div_ctrl;
	div_stat_t         div_stat;
	logic [WORD_W-1:0] quotient;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// slow start step and congestion threshold
	assign ss_sum = {1'b0, window_q} + {{(WORD_W+1-SEG_W){1'b0}}, seg_q};
	assign ss_win = ss_sum[WORD_W] ? WIN_MAX : ss_sum[WORD_W-1:0];
	assign half   = {1'b0, bytes_in_flight[WORD_W-1:1]};
	assign floor2 = {{(WORD_W-SEG_W-1){1'b0}}, seg_q, 1'b0};

	// segment size widened so the square keeps all of its bits
	assign seg_word = {{(WORD_W-SEG_W){1'b0}}, seg_q};

	// avoidance increment, at least one byte
	assign inc    = (quotient == '0) ? WORD_W'(1) : quotient;
	assign ca_sum = {1'b0, window_q} + {1'b0, inc};
	assign ca_win = ca_sum[WORD_W] ? WIN_MAX : ca_sum[WORD_W-1:0];

	assign div_ctrl.start = (state_q == ST_START);

	nwu_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (sq_q),
		.divisor  (dsr_q),
		.stat     (div_stat),
		.quotient (quotient)
	);

	// sequencer, configuration and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seg_q       <= RST_SEGMENT_SIZE;
			window_q    <= RST_INITIAL_WINDOW;
			threshold_q <= RST_INITIAL_THRESHOLD;
			left_q      <= '0;
			sq_q        <= '0;
			dsr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SEGMENT_SIZE: seg_q <= cfg_data[SEG_W-1:0];
					REG_INITIAL_WINDOW: begin
						window_q   <= cfg_data;
					end
					REG_INITIAL_THRESHOLD: begin
						threshold_q <= cfg_data;
					end
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (operation == OP_CONGESTION) begin
							threshold_q <= (half > floor2) ? half : floor2;
							left_q      <= '0;
							state_q     <= ST_FINISH;
						end else begin
							if (window_q < threshold_q && segments_acked != '0) begin
								window_q <= ss_win;
								left_q   <= segments_acked - 1'b1;
							end else begin
								left_q   <= segments_acked;
							end
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (window_q >= threshold_q && left_q != '0) begin
						sq_q    <= seg_word * seg_word;
						dsr_q   <= (window_q == '0) ? WORD_W'(1) : window_q;
						state_q <= ST_START;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						window_q <= ca_win;
						state_q  <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register, loaded when the item completes
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			out_win_q  <= window_q;
			out_thr_q  <= threshold_q;
			out_left_q <= left_q;
			out_ss_q   <= (window_q < threshold_q);
		end
	end

	assign out_valid       = out_valid_q;
	assign window_bytes    = out_win_q;
	assign threshold_bytes = out_thr_q;
	assign unused_segments = out_left_q;
	assign in_slow_start   = out_ss_q;

endmodule : newreno_window_update
`default_nettype wire

// ----- bench/newreno_window_update_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newreno_window_update_tb: self-checking bench for the NewReno window update
// Sends acknowledgements and congestion events over valid/ready, predicts the
// window, threshold, leftover segments and slow start flag for every item and
// compares each result as it leaves the block. Random idling on both sides.
// ----------------------------------------------------------------------------
module newreno_window_update_tb;
	import nwu_pkg::*;

	// index past the last register, must be ignored
	localparam logic [CIDX_W-1:0] REG_NONE = 2'd3;
	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic [WORD_W-1:0] window;
		logic [WORD_W-1:0] threshold;
		logic [ACK_W-1:0]  unused;
		logic              slow;
	} window_result_t;

	logic                clk             = 1'b0;
	logic                arst_n          = 1'b0;
	logic                cfg_we          = 1'b0;
	logic [CIDX_W-1:0]   cfg_index       = '0;
	logic [WORD_W-1:0]   cfg_data        = '0;
	logic                in_valid        = 1'b0;
	logic                in_ready;
	logic                operation       = OP_ACK;
	logic [ACK_W-1:0]    segments_acked  = '0;
	logic [WORD_W-1:0]   bytes_in_flight = '0;
	logic                out_valid;
	logic                out_ready       = 1'b0;
	logic [WORD_W-1:0]   window_bytes;
	logic [WORD_W-1:0]   threshold_bytes;
	logic [ACK_W-1:0]    unused_segments;
	logic                in_slow_start;

	// predicted block state and settings
	logic [SEG_W-1:0]    seg_size      = RST_SEGMENT_SIZE;
	logic [WORD_W-1:0]   cur_window    = RST_INITIAL_WINDOW;
	logic [WORD_W-1:0]   cur_threshold = RST_INITIAL_THRESHOLD;

	window_result_t      expected_windows[$];
	int                  mismatch_count = 0;
	int                  tx_idle_pct    = 0;
	int                  rx_idle_pct    = 0;

	newreno_window_update DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.segments_acked  (segments_acked),
		.bytes_in_flight (bytes_in_flight),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.window_bytes    (window_bytes),
		.threshold_bytes (threshold_bytes),
		.unused_segments (unused_segments),
		.in_slow_start   (in_slow_start)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// stall the result side at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	function automatic logic [WORD_W-1:0] grow_saturated(input logic [WORD_W-1:0] base,
			input logic [WORD_W-1:0] add);
		logic [WORD_W:0] sum;
		sum = {1'b0, base} + {1'b0, add};
		return sum[WORD_W] ? WIN_MAX : sum[WORD_W-1:0];
	endfunction

	// advance the predicted window and threshold by one item, queue the result
	function automatic void predict_window_update(input logic op,
			input logic [ACK_W-1:0] acked, input logic [WORD_W-1:0] flight);
		logic [ACK_W-1:0]  left;
		logic [WORD_W-1:0] seg_word;
		logic [WORD_W-1:0] seg_sq;
		logic [WORD_W-1:0] divisor;
		logic [WORD_W-1:0] incr;
		logic [WORD_W-1:0] half;
		window_result_t    res;
		seg_word = {{(WORD_W-SEG_W){1'b0}}, seg_size};
		if (op == OP_ACK) begin
			left = acked;
			// slow start: one segment, consumes one acknowledged segment
			if (cur_window < cur_threshold && acked != '0) begin
				cur_window = grow_saturated(cur_window, seg_word);
				left = acked - 1'b1;
			end
			// congestion avoidance: seg*seg/window, at least one byte
			if (cur_window >= cur_threshold && left != '0) begin
				seg_sq  = seg_word * seg_word;
				divisor = (cur_window == '0) ? 32'd1 : cur_window;
				incr    = seg_sq / divisor;
				if (incr == '0)
					incr = 32'd1;
				cur_window = grow_saturated(cur_window, incr);
			end
		end else begin
			half = flight >> 1;
			cur_threshold = (half > (seg_word << 1)) ? half : (seg_word << 1);
			left = '0;
		end
		res.window    = cur_window;
		res.threshold = cur_threshold;
		res.unused    = left;
		res.slow      = (cur_window < cur_threshold);
		expected_windows.push_back(res);
	endfunction

	task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		if (mismatch_count < MAX_PRINTED)
			$display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin : check_results
		window_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_windows.size() == 0) begin
				report_mismatch("result with nothing pending", window_bytes, '0);
			end else begin
				want = expected_windows.pop_front();
				if (window_bytes !== want.window)
					report_mismatch("window_bytes", window_bytes, want.window);
				if (threshold_bytes !== want.threshold)
					report_mismatch("threshold_bytes", threshold_bytes, want.threshold);
				if (unused_segments !== want.unused)
					report_mismatch("unused_segments", WORD_W'(unused_segments),
						WORD_W'(want.unused));
				if (in_slow_start !== want.slow)
					report_mismatch("in_slow_start", WORD_W'(in_slow_start),
						WORD_W'(want.slow));
			end
		end
	end

	// hold valid until accepted, with an optional gap before it
	task automatic send_item(input logic op, input logic [ACK_W-1:0] acked,
			input logic [WORD_W-1:0] flight);
		int gap;
		gap = 0;
		if ($urandom_range(0, 99) < tx_idle_pct)
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 45) : $urandom_range(1, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		operation       <= op;
		segments_acked  <= acked;
		bytes_in_flight <= flight;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_window_update(op, acked, flight);
	endtask

	// drop valid and wait until every predicted result has been taken
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (expected_windows.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_SEGMENT_SIZE: seg_size = data[SEG_W-1:0];
			REG_INITIAL_WINDOW: cur_window = data;
			REG_INITIAL_THRESHOLD: cur_threshold = data;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// reset settings: slow start, floor threshold, avoidance, large flight
	task automatic test_reset_defaults();
		send_item(OP_ACK, 8'd0, 32'd0);
		send_item(OP_ACK, 8'd1, 32'hFFFF_FFFF);
		send_item(OP_ACK, 8'd255, 32'd0);
		send_item(OP_CONGESTION, 8'd255, 32'd0);
		send_item(OP_ACK, 8'd3, 32'd0);
		send_item(OP_CONGESTION, 8'd0, 32'hFFFF_FFFF);
		send_item(OP_ACK, 8'd1, 32'd0);
	endtask

	task automatic test_special_cases();
		// zero segment size, upper data bits dropped
		wait_for_drain();
		write_reg(REG_SEGMENT_SIZE, 32'hFFFF_0000);
		send_item(OP_CONGESTION, 8'd7, 32'd1);
		send_item(OP_ACK, 8'd1, 32'd0);
		// zero window as divisor
		wait_for_drain();
		write_reg(REG_SEGMENT_SIZE, 32'd1000);
		write_reg(REG_INITIAL_WINDOW, 32'd0);
		send_item(OP_ACK, 8'd1, 32'd0);
		// slow start step crossing the threshold, then avoidance in one item
		wait_for_drain();
		write_reg(REG_SEGMENT_SIZE, 32'd536);
		write_reg(REG_INITIAL_WINDOW, 32'd1000);
		write_reg(REG_INITIAL_THRESHOLD, 32'd1200);
		send_item(OP_ACK, 8'd2, 32'd0);
		// slow start saturates at the top
		wait_for_drain();
		write_reg(REG_SEGMENT_SIZE, 32'd65535);
		write_reg(REG_INITIAL_THRESHOLD, 32'hFFFF_FFFF);
		write_reg(REG_INITIAL_WINDOW, 32'hFFFF_FFF0);
		send_item(OP_ACK, 8'd1, 32'd0);
		// avoidance saturates at the top
		wait_for_drain();
		write_reg(REG_INITIAL_THRESHOLD, 32'd1);
		write_reg(REG_INITIAL_WINDOW, 32'hFFFF_FFFF);
		send_item(OP_ACK, 8'd5, 32'd0);
		// unknown register index leaves everything alone
		wait_for_drain();
		write_reg(REG_NONE, 32'hFFFF_FFFF);
		send_item(OP_ACK, 8'd1, 32'd0);
		send_item(OP_CONGESTION, 8'd1, 32'hFFFF_FFFF);
		send_item(OP_CONGESTION, 8'd0, 32'd262139);
	endtask

	// one setting, then random traffic shaped around the predicted window
	task automatic run_random_phase(input logic [SEG_W-1:0] seg, input logic [WORD_W-1:0] win,
			input logic [WORD_W-1:0] thr, input int n_items);
		logic              op;
		logic [ACK_W-1:0]  acked;
		logic [WORD_W-1:0] flight;
		logic [WORD_W-1:0] seg_data;
		int                pick;
		wait_for_drain();
		seg_data = $urandom;
		seg_data[SEG_W-1:0] = seg;
		write_reg(REG_SEGMENT_SIZE, seg_data);
		write_reg(REG_INITIAL_WINDOW, win);
		write_reg(REG_INITIAL_THRESHOLD, thr);
		for (int i = 0; i < n_items; i++) begin
			op = ($urandom_range(0, 99) < 15) ? OP_CONGESTION : OP_ACK;
			pick = $urandom_range(0, 9);
			if (pick == 0)
				acked = '0;
			else if (pick == 1)
				acked = 8'hFF;
			else if (pick < 7)
				acked = ACK_W'($urandom_range(1, 3));
			else
				acked = ACK_W'($urandom_range(0, 255));
			pick = $urandom_range(0, 3);
			if (pick == 0)
				flight = $urandom;
			else if (pick == 1)
				flight = $urandom_range(0, 8 * seg_size);
			else
				flight = $urandom_range(0, cur_window) << 1;
			send_item(op, acked, flight);
			// now and then let everything drain before going on
			if ($urandom_range(0, 149) == 0)
				wait_for_drain();
		end
	endtask

	task automatic test_random_traffic();
		run_random_phase(16'd536, 32'd5360, 32'hFFFF_FFFF, 330);
		run_random_phase(16'hFFFF, 32'd1, 32'd200000, 330);
		tx_idle_pct = 84;
		rx_idle_pct = 23;
		run_random_phase(16'd1, 32'hFFFF_0000, 32'hFFFF_FFFF, 330);
		run_random_phase(16'd1460, 32'd14600, 32'd30000, 330);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random_phase(16'd0, 32'd0, 32'd1, 330);
		run_random_phase(16'($urandom_range(1, 65535)), $urandom, $urandom, 330);
	endtask

	initial begin
		tx_idle_pct = 23;
		rx_idle_pct = 84;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_special_cases();
		test_random_traffic();
		wait_for_drain();
		repeat (50) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// give up on a hung run
	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
